>>> design/aepa_pkg.sv
package aepa_pkg;

  localparam int unsigned MaxPaths = 1048576;
  localparam int PathW = 21;
  localparam int QDepth = 2;

  localparam logic [31:0] SpotReset   = 32'd6553600;
  localparam logic [31:0] StrikeReset = 32'd6553600;
  localparam logic [29:0] RateReset   = 30'd13421773;
  localparam logic [30:0] VolReset    = 31'd214748365;
  localparam logic [29:0] MatReset    = 30'd16777216;
  localparam logic [20:0] PathsReset  = 21'd1024;

  // exp range reduction: x = k*ln2 + f
  localparam logic [23:0] Ln2Q24    = 24'd11629080;
  localparam logic [8:0]  Ln2Recip  = 9'd369;          // floor(2^32 / ln2_q24)
  localparam logic [7:0]  ExpKBias  = 8'd93;           // k = q - bias
  localparam logic [30:0] ExpOffset = 31'(93 * 11629080);
  localparam logic signed [33:0] ExpHi = 34'sd536870912;
  localparam logic signed [33:0] ExpLo = -34'sd1073741824;
  localparam logic [31:0] OneQ30    = 32'h4000_0000;
  localparam logic [3:0]  ExpTerms  = 4'd12;
  localparam logic [7:0]  ExpSatQ   = 8'd124;          // k >= 31
  localparam logic [7:0]  ExpShiftQ = 8'd91;           // shift = q - 91

  typedef enum logic [2:0] {
    CfgSpot, CfgStrike, CfgRate, CfgVol, CfgMat, CfgIsCall, CfgPaths
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0]        spot;
    logic [31:0]        strike;
    logic signed [29:0] rate;
    logic [30:0]        volatility;
    logic [29:0]        maturity;
    logic               is_call;
    logic [20:0]        path_count;
  } cfg_t;

  typedef struct packed {
    logic        neg;
    logic [31:0] mag;
  } item_t;

  typedef struct packed {
    logic               start;
    logic signed [33:0] x;
  } exp_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] value;
  } exp_rsp_t;

  typedef enum logic [2:0] {
    EX_IDLE, EX_QUO, EX_REM, EX_FIX, EX_MUL, EX_DIV, EX_ACC, EX_SHIFT
  } exp_state_t;

  typedef enum logic [4:0] {
    B_IDLE, B_HSQ, B_DIFF, B_DMUL, B_DRIFT, B_SQRT, B_VMUL, B_VTERM,
    B_RMUL, B_RT, B_RWAIT, B_ZMUL, B_X, B_EWAIT, B_TMUL, B_TLO, B_TSUM,
    B_PAY, B_DIV, B_MLO, B_MHI, B_FIN, B_OUT
  } back_state_t;

  // floor(2^32 / i) for the Horner divide steps
  function automatic logic [32:0] div_recip(logic [3:0] i);
    logic [32:0] r;
    case (i)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/aepa_if.sv
interface aepa_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] normal_sample;
  modport source (output valid, output normal_sample, input ready);
  modport sink (input valid, input normal_sample, output ready);
endinterface

interface aepa_price_if;
  logic        valid;
  logic        ready;
  logic [31:0] price;
  modport source (output valid, output price, input ready);
  modport sink (input valid, input price, output ready);
endinterface

interface aepa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/aepa_front.sv
module aepa_front (
  input  logic                 clk,
  input  logic                 rst,
  aepa_sample_if.sink          sample_ch,
  output logic                 q_valid,
  output aepa_pkg::item_t      q_item,
  input  logic                 q_pop
);

  aepa_pkg::item_t slot [aepa_pkg::QDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  aepa_pkg::item_t in_item;

  assign sample_ch.ready = (cnt != 2'(aepa_pkg::QDepth));
  assign push = sample_ch.valid && sample_ch.ready;

  // sign and magnitude split of Z
  assign in_item.neg = sample_ch.normal_sample[31];
  assign in_item.mag = sample_ch.normal_sample[31] ? 32'(-sample_ch.normal_sample)
                                                   : 32'(sample_ch.normal_sample);

  assign q_valid = (cnt != 2'd0);
  assign q_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (cnt != 2'd0)) else $error("pop from empty queue");

endmodule

>>> design/aepa_exp.sv
module aepa_exp (
  input  logic                  clk,
  input  logic                  rst,
  input  aepa_pkg::exp_req_t    req,
  output aepa_pkg::exp_rsp_t    rsp
);

  aepa_pkg::exp_state_t state, state_next;

  logic [30:0] xo;
  logic [7:0]  qe;
  logic [24:0] rem;
  logic [7:0]  q;
  logic [29:0] f;
  logic [31:0] t;
  logic [61:0] mp;
  logic [31:0] yr;
  logic [31:0] qd;
  logic [3:0]  term;
  logic [63:0] value;
  logic        done;

  logic signed [33:0] xc;
  logic [39:0] qprod;
  logic [31:0] qln;
  logic [31:0] y;
  logic [64:0] dprod;
  logic [35:0] r2;
  logic [24:0] rfix;
  logic [7:0]  qfix;

  always_comb begin
    if (req.x > aepa_pkg::ExpHi) xc = aepa_pkg::ExpHi;
    else if (req.x < aepa_pkg::ExpLo) xc = aepa_pkg::ExpLo;
    else xc = req.x;
    qprod = 40'(xo) * 40'(aepa_pkg::Ln2Recip);
    qln   = 32'(qe) * 32'(aepa_pkg::Ln2Q24);
    if (rem >= 25'(aepa_pkg::Ln2Q24)) begin
      rfix = rem - 25'(aepa_pkg::Ln2Q24);
      qfix = qe + 8'd1;
    end else begin
      rfix = rem;
      qfix = qe;
    end
    y     = mp[61:30];
    dprod = 65'(y) * 65'(aepa_pkg::div_recip(term));
    r2    = 36'(yr) - 36'(qd) * 36'(term);
  end

  always_comb begin
    state_next = state;
    case (state)
      aepa_pkg::EX_IDLE:  if (req.start) state_next = aepa_pkg::EX_QUO;
      aepa_pkg::EX_QUO:   state_next = aepa_pkg::EX_REM;
      aepa_pkg::EX_REM:   state_next = aepa_pkg::EX_FIX;
      aepa_pkg::EX_FIX:   state_next = aepa_pkg::EX_MUL;
      aepa_pkg::EX_MUL:   state_next = aepa_pkg::EX_DIV;
      aepa_pkg::EX_DIV:   state_next = aepa_pkg::EX_ACC;
      aepa_pkg::EX_ACC:   state_next = (term == 4'd1) ? aepa_pkg::EX_SHIFT
                                                      : aepa_pkg::EX_MUL;
      aepa_pkg::EX_SHIFT: state_next = aepa_pkg::EX_IDLE;
      default:            state_next = aepa_pkg::EX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aepa_pkg::EX_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == aepa_pkg::EX_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      aepa_pkg::EX_IDLE: xo <= 31'(xc + 34'(aepa_pkg::ExpOffset));
      aepa_pkg::EX_QUO:  qe <= qprod[39:32];
      aepa_pkg::EX_REM:  rem <= 25'(32'(xo) - qln);
      aepa_pkg::EX_FIX: begin
        q    <= qfix;
        f    <= {rfix[23:0], 6'b0};
        t    <= aepa_pkg::OneQ30;
        term <= aepa_pkg::ExpTerms;
      end
      aepa_pkg::EX_MUL:  mp <= 62'(t) * 62'(f);
      aepa_pkg::EX_DIV: begin
        qd <= dprod[63:32];
        yr <= y;
      end
      aepa_pkg::EX_ACC: begin
        t    <= aepa_pkg::OneQ30 + qd + 32'(r2 >= 36'(term));
        term <= term - 4'd1;
      end
      aepa_pkg::EX_SHIFT: begin
        if (q >= aepa_pkg::ExpSatQ) value <= '1;
        else if (q >= aepa_pkg::ExpShiftQ) value <= 64'(t) << (q - aepa_pkg::ExpShiftQ);
        else value <= 64'(t) >> (aepa_pkg::ExpShiftQ - q);
      end
      default: ;
    endcase
  end

  assign rsp.done  = done;
  assign rsp.value = value;

endmodule

>>> design/aepa_back.sv
module aepa_back (
  input  logic                 clk,
  input  logic                 rst,
  input  aepa_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  aepa_pkg::item_t      q_item,
  output logic                 q_pop,
  output aepa_pkg::exp_req_t   exp_req,
  input  aepa_pkg::exp_rsp_t   exp_rsp,
  output logic                 price_valid,
  input  logic                 price_ready,
  output logic [31:0]          price
);

  aepa_pkg::back_state_t state, state_next;

  // run state
  logic [63:0] payoff_sum;
  logic [20:0] paths_seen;
  logic [31:0] drift_term;
  logic [31:0] vol_term;
  logic [31:0] discount_factor;

  // datapath
  logic [65:0] pm;
  logic [32:0] ma, mb;
  logic        neg;
  logic [31:0] mag;
  logic        dneg;
  logic [31:0] dmag;
  logic [55:0] sv, sres;
  logic [4:0]  sb;
  logic        rneg;
  logic signed [33:0] x2;
  logic [63:0] ev;
  logic        side;
  logic        tsat;
  logic [31:0] alo;
  logic [31:0] st;
  logic [53:0] dq;
  logic [21:0] drem;
  logic [21:0] dv;
  logic [5:0]  dcnt;
  logic [63:0] mlo;
  logic [31:0] res;

  // combinational helpers
  logic signed [32:0] dval;
  logic [31:0] dm;
  logic [31:0] drift_sat;
  logic [55:0] sbit, strial;
  logic [29:0] rmag;
  logic [29:0] rtm;
  logic [30:0] vmag;
  logic signed [33:0] vs, dr, x1;
  logic [32:0] tsum;
  logic [31:0] payoff;
  logic [20:0] n;
  logic [21:0] ps_inc;
  logic        run_end;
  logic [22:0] rem_s;
  logic        qbit;
  logic [63:0] tot;

  always_comb begin
    dval = {{3{cfg.rate[29]}}, cfg.rate} - {2'b0, pm[61:31]};
    dm   = pm[61:30];
    if (dneg) drift_sat = (dm > 32'h8000_0000) ? 32'h8000_0000 : 32'(-dm);
    else drift_sat = (dm > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : dm;
    sbit   = 56'(1) << {sb, 1'b0};
    strial = sres + sbit;
    rmag   = cfg.rate[29] ? 30'(-cfg.rate) : 30'(cfg.rate);
    rtm    = pm[59:30];
    vmag   = pm[58:28];
    vs     = neg ? -34'(vmag) : 34'(vmag);
    dr     = 34'(signed'(drift_term));
    x1     = dr + vs;
    tsum   = {1'b0, alo} + {1'b0, pm[63:32]};
    if (cfg.is_call) payoff = (st > cfg.strike) ? st - cfg.strike : 32'd0;
    else payoff = (cfg.strike > st) ? cfg.strike - st : 32'd0;
    if (cfg.path_count == 21'd0) n = 21'd1;
    else if (cfg.path_count > 21'(aepa_pkg::MaxPaths)) n = 21'(aepa_pkg::MaxPaths);
    else n = cfg.path_count;
    ps_inc  = {1'b0, paths_seen} + 22'd1;
    run_end = (ps_inc >= {1'b0, n});
    rem_s   = {drem, dq[53]};
    qbit    = (rem_s >= {1'b0, dv});
    // mean * discount kept to 64 bits, then scaled down
    tot     = {pm[31:0], 32'b0} + mlo;
  end

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      aepa_pkg::B_HSQ:  begin ma = 33'(cfg.volatility); mb = 33'(cfg.volatility); end
      aepa_pkg::B_DMUL: begin ma = 33'(dmag);           mb = 33'(cfg.maturity);   end
      aepa_pkg::B_VMUL: begin ma = 33'(cfg.volatility); mb = 33'(sres[27:0]);     end
      aepa_pkg::B_RMUL: begin ma = 33'(rmag);           mb = 33'(cfg.maturity);   end
      aepa_pkg::B_ZMUL: begin ma = 33'(vol_term);       mb = 33'(mag);            end
      aepa_pkg::B_TMUL: begin ma = 33'(cfg.spot);       mb = 33'(ev[63:32]);      end
      aepa_pkg::B_TLO:  begin ma = 33'(cfg.spot);       mb = 33'(ev[31:0]);       end
      aepa_pkg::B_MLO:  begin ma = 33'(dq[31:0]);       mb = 33'(discount_factor); end
      aepa_pkg::B_MHI:  begin ma = 33'(dq[53:32]);      mb = 33'(discount_factor); end
      default: ;
    endcase
  end

  always_comb begin
    exp_req.start = 1'b0;
    exp_req.x     = x1;
    case (state)
      aepa_pkg::B_RT: begin
        exp_req.start = 1'b1;
        exp_req.x     = rneg ? 34'(rtm) : -34'(rtm);
      end
      aepa_pkg::B_X: exp_req.start = 1'b1;
      aepa_pkg::B_PAY: begin
        exp_req.start = !side;
        exp_req.x     = x2;
      end
      default: ;
    endcase
  end

  assign q_pop = (state == aepa_pkg::B_IDLE) && q_valid;

  always_comb begin
    state_next = state;
    case (state)
      aepa_pkg::B_IDLE:  if (q_valid) state_next = (paths_seen == 21'd0) ? aepa_pkg::B_HSQ
                                                                         : aepa_pkg::B_ZMUL;
      aepa_pkg::B_HSQ:   state_next = aepa_pkg::B_DIFF;
      aepa_pkg::B_DIFF:  state_next = aepa_pkg::B_DMUL;
      aepa_pkg::B_DMUL:  state_next = aepa_pkg::B_DRIFT;
      aepa_pkg::B_DRIFT: state_next = aepa_pkg::B_SQRT;
      aepa_pkg::B_SQRT:  if (sb == 5'd0) state_next = aepa_pkg::B_VMUL;
      aepa_pkg::B_VMUL:  state_next = aepa_pkg::B_VTERM;
      aepa_pkg::B_VTERM: state_next = aepa_pkg::B_RMUL;
      aepa_pkg::B_RMUL:  state_next = aepa_pkg::B_RT;
      aepa_pkg::B_RT:    state_next = aepa_pkg::B_RWAIT;
      aepa_pkg::B_RWAIT: if (exp_rsp.done) state_next = aepa_pkg::B_ZMUL;
      aepa_pkg::B_ZMUL:  state_next = aepa_pkg::B_X;
      aepa_pkg::B_X:     state_next = aepa_pkg::B_EWAIT;
      aepa_pkg::B_EWAIT: if (exp_rsp.done) state_next = aepa_pkg::B_TMUL;
      aepa_pkg::B_TMUL:  state_next = aepa_pkg::B_TLO;
      aepa_pkg::B_TLO:   state_next = aepa_pkg::B_TSUM;
      aepa_pkg::B_TSUM:  state_next = aepa_pkg::B_PAY;
      aepa_pkg::B_PAY: begin
        if (!side) state_next = aepa_pkg::B_EWAIT;
        else if (run_end) state_next = aepa_pkg::B_DIV;
        else state_next = aepa_pkg::B_IDLE;
      end
      aepa_pkg::B_DIV:   if (dcnt == 6'd1) state_next = aepa_pkg::B_MLO;
      aepa_pkg::B_MLO:   state_next = aepa_pkg::B_MHI;
      aepa_pkg::B_MHI:   state_next = aepa_pkg::B_FIN;
      aepa_pkg::B_FIN:   state_next = aepa_pkg::B_OUT;
      aepa_pkg::B_OUT:   if (!price_valid) state_next = aepa_pkg::B_IDLE;
      default:           state_next = aepa_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= aepa_pkg::B_IDLE;
      payoff_sum      <= '0;
      paths_seen      <= '0;
      drift_term      <= '0;
      vol_term        <= '0;
      discount_factor <= '0;
      price_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (price_valid && price_ready) price_valid <= 1'b0;
      case (state)
        aepa_pkg::B_DRIFT: drift_term <= drift_sat;
        aepa_pkg::B_VTERM: vol_term <= pm[61:30];
        aepa_pkg::B_RWAIT: if (exp_rsp.done) begin
          discount_factor <= (|exp_rsp.value[63:40]) ? 32'hFFFF_FFFF
                                                     : exp_rsp.value[39:8];
        end
        aepa_pkg::B_PAY: begin
          if (side) begin
            if (run_end) begin
              payoff_sum <= '0;
              paths_seen <= '0;
            end else begin
              payoff_sum <= payoff_sum + 64'(payoff);
              paths_seen <= ps_inc[20:0];
            end
          end else begin
            payoff_sum <= payoff_sum + 64'(payoff);
          end
        end
        aepa_pkg::B_OUT: if (!price_valid) price_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pm <= 66'(ma) * 66'(mb);
    case (state)
      aepa_pkg::B_IDLE: begin
        neg <= q_item.neg;
        mag <= q_item.mag;
      end
      aepa_pkg::B_DIFF: begin
        dneg <= dval[32];
        dmag <= dval[32] ? 32'(-dval) : 32'(dval);
      end
      aepa_pkg::B_DRIFT: begin
        sv   <= {2'b0, cfg.maturity, 24'b0};
        sres <= '0;
        sb   <= 5'd27;
      end
      aepa_pkg::B_SQRT: begin
        if (sv >= strial) begin
          sv   <= sv - strial;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sb <= sb - 5'd1;
      end
      aepa_pkg::B_RMUL: rneg <= cfg.rate[29];
      aepa_pkg::B_X: begin
        x2   <= dr - vs;
        side <= 1'b0;
      end
      aepa_pkg::B_EWAIT: if (exp_rsp.done) ev <= exp_rsp.value;
      aepa_pkg::B_TLO: begin
        tsat <= |pm[65:32];
        alo  <= pm[31:0];
      end
      aepa_pkg::B_TSUM: st <= (tsat || tsum[32]) ? 32'hFFFF_FFFF : tsum[31:0];
      aepa_pkg::B_PAY: begin
        side <= 1'b1;
        if (side && run_end) begin
          dq   <= payoff_sum[53:0] + 54'(payoff);
          drem <= '0;
          dv   <= {n, 1'b0};
          dcnt <= 6'd54;
        end
      end
      aepa_pkg::B_DIV: begin
        drem <= qbit ? 22'(rem_s - {1'b0, dv}) : rem_s[21:0];
        dq   <= {dq[52:0], qbit};
        dcnt <= dcnt - 6'd1;
      end
      aepa_pkg::B_MHI: mlo <= pm[63:0];
      aepa_pkg::B_FIN: res <= (|tot[63:56]) ? 32'hFFFF_FFFF : tot[55:24];
      aepa_pkg::B_OUT: if (!price_valid) price <= res;
      default: ;
    endcase
  end

  a_paths_bound: assert property (@(posedge clk) disable iff (rst)
    paths_seen <= 21'(aepa_pkg::MaxPaths)) else $error("path counter overrun");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    payoff_sum[63:54] == 10'd0) else $error("payoff sum beyond its range");

  a_exp_expected: assert property (@(posedge clk) disable iff (rst)
    exp_rsp.done |-> (state == aepa_pkg::B_EWAIT || state == aepa_pkg::B_RWAIT))
    else $error("exp result with no waiting step");

endmodule

>>> design/antithetic_european_payoff_averager.sv
// channel    dir  handshake        payload
// sample_ch  in   valid / ready    normal_sample  Q4.28 signed
// price_ch   out  valid / ready    price          Q16.16 unsigned
// cfg_ch     in   valid / ready    index, data    register write
//
// Each request runs two exponentials on the shared iterative
// exp unit (a Taylor series in Horner form) plus the price steps.
// A run start adds a square root and a third exponential.
// A run end adds a restoring divide, the scaling steps and an output
// step, which holds while an earlier price is still waiting.
// rst is synchronous and clears the run (sum, count, derived terms) and loads
// register defaults. A two-entry queue takes samples while the back end works;
// a waiting price does not stop sample intake until the queue is full.
module antithetic_european_payoff_averager (
  input  logic          clk,
  input  logic          rst,
  aepa_sample_if.sink   sample_ch,
  aepa_price_if.source  price_ch,
  aepa_cfg_if.sink      cfg_ch
);

  aepa_pkg::cfg_t     cfg;
  logic               q_valid;
  aepa_pkg::item_t    q_item;
  logic               q_pop;
  aepa_pkg::exp_req_t exp_req;
  aepa_pkg::exp_rsp_t exp_rsp;

  // register file; writes are always taken
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spot       <= aepa_pkg::SpotReset;
      cfg.strike     <= aepa_pkg::StrikeReset;
      cfg.rate       <= aepa_pkg::RateReset;
      cfg.volatility <= aepa_pkg::VolReset;
      cfg.maturity   <= aepa_pkg::MatReset;
      cfg.is_call    <= 1'b1;
      cfg.path_count <= aepa_pkg::PathsReset;
    end else if (cfg_ch.valid) begin
      case (aepa_pkg::cfg_idx_t'(cfg_ch.index))
        aepa_pkg::CfgSpot:   cfg.spot       <= cfg_ch.data;
        aepa_pkg::CfgStrike: cfg.strike     <= cfg_ch.data;
        aepa_pkg::CfgRate:   cfg.rate       <= cfg_ch.data[29:0];
        aepa_pkg::CfgVol:    cfg.volatility <= cfg_ch.data[30:0];
        aepa_pkg::CfgMat:    cfg.maturity   <= cfg_ch.data[29:0];
        aepa_pkg::CfgIsCall: cfg.is_call    <= cfg_ch.data[0];
        aepa_pkg::CfgPaths:  cfg.path_count <= cfg_ch.data[20:0];
        default: ;  // unused index, dropped
      endcase
    end
  end

  // front end: sample intake, sign/magnitude split, queue
  aepa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // shared exponential unit
  aepa_exp u_exp (
    .clk (clk),
    .rst (rst),
    .req (exp_req),
    .rsp (exp_rsp)
  );

  // back end: run setup, payoffs, accumulation, final scaling
  aepa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .exp_req     (exp_req),
    .exp_rsp     (exp_rsp),
    .price_valid (price_ch.valid),
    .price_ready (price_ch.ready),
    .price       (price_ch.price)
  );

endmodule

>>> tb/tb.sv
module tb;

  // Fixed-point constants used by the price predictor
  localparam longint         Ln2Fix   = 64'sd11629080;         // ln2 in Q.24
  localparam logic [63:0]    OneFix   = 64'h4000_0000;         // 1.0 in Q2.30
  localparam longint         ArgHi    = 64'sd32 * 64'sd16777216;
  localparam longint         ArgLo    = -64'sd64 * 64'sd16777216;
  localparam logic [63:0]    Sat32    = 64'hFFFF_FFFF;
  localparam logic [2:0]     CfgNone  = 3'd7;                  // index past the list
  localparam int             SettleCycles = 400;
  localparam int             StallLimit   = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  aepa_sample_if sample_ch ();
  aepa_price_if  price_ch ();
  aepa_cfg_if    cfg_ch ();

  antithetic_european_payoff_averager dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .price_ch  (price_ch),
    .cfg_ch    (cfg_ch)
  );

  always #5 clk = ~clk;

  // Predictor copy of registers and run state
  aepa_pkg::cfg_t regs;
  logic [63:0] run_sum;
  logic [20:0] run_seen;
  logic [31:0] run_drift;
  logic [31:0] run_vol;
  logic [31:0] run_disc;

  logic [31:0] price_q[$];   // expected prices, oldest first

  int idle_pct  = 0;         // sender idle chance per cycle
  int stall_pct = 0;         // receiver stall chance per cycle
  int errors    = 0;
  int n_samples = 0;
  int n_prices  = 0;
  int n_writes  = 0;
  int quiet     = 0;

  // ---------------------------------------------------------------------------
  // Price arithmetic
  // ---------------------------------------------------------------------------

  // shift right, rounding toward zero
  function automatic longint shr_tz(longint v, int s);
    logic [63:0] m;
    m = (v < 0) ? 64'(-v) : 64'(v);
    m = m >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'h1 << 62;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // e^x for x in Q.24, result in Q32.32
  function automatic logic [63:0] exp_fix(longint x);
    longint      k, sh;
    logic [63:0] f, t;
    t = OneFix;
    if (x > ArgHi) x = ArgHi;
    if (x < ArgLo) x = ArgLo;
    k = x / Ln2Fix;
    if (x < 0 && (x % Ln2Fix) != 0) k = k - 1;
    f = 64'(x - k * Ln2Fix) << 6;
    for (int i = 12; i >= 1; i--) t = OneFix + ((t * f) >> 30) / 64'(i);
    if (k >= 31) return '1;
    sh = k + 2;
    if (sh >= 0) return t << sh;
    if (-sh >= 64) return '0;
    return t >> (-sh);
  endfunction

  function automatic logic [63:0] payoff_at(longint x);
    logic [63:0] e, a, st;
    e = exp_fix(x);
    a = 64'(regs.spot) * (e >> 32);
    if (a > Sat32) st = Sat32;
    else begin
      a  = a + ((64'(regs.spot) * 64'(e[31:0])) >> 32);
      st = (a > Sat32) ? Sat32 : a;
    end
    if (regs.is_call) return (st > 64'(regs.strike)) ? st - 64'(regs.strike) : '0;
    return (64'(regs.strike) > st) ? 64'(regs.strike) - st : '0;
  endfunction

  // derived terms latched when a run opens
  function automatic void open_run();
    logic [63:0] sig, root, dsc;
    longint      half_sq, d, drift, rt;
    sig     = 64'(regs.volatility);
    half_sq = longint'((sig * sig) >> 31);
    d       = longint'(regs.rate) - half_sq;
    drift   = shr_tz(d * longint'(regs.maturity), 30);
    root    = floor_sqrt(64'(regs.maturity) << 24);
    rt      = shr_tz(longint'(regs.rate) * longint'(regs.maturity), 30);
    if (drift > 64'sd2147483647) drift = 64'sd2147483647;
    if (drift < -64'sd2147483648) drift = -64'sd2147483648;
    run_drift = drift[31:0];
    run_vol   = 32'((sig * root) >> 30);
    dsc       = exp_fix(-rt) >> 8;
    run_disc  = (dsc > Sat32) ? 32'hFFFF_FFFF : dsc[31:0];
  endfunction

  // one accepted draw: update the sum, queue a price when the run closes
  function automatic void price_draw(logic signed [31:0] z);
    logic [63:0] mag, n, mean, p;
    longint      v, x1, x2;
    if (run_seen == 0) open_run();
    mag = (z < 0) ? 64'(-longint'(z)) : 64'(longint'(z));
    v   = longint'((64'(run_vol) * mag) >> 28);
    if (z < 0) v = -v;
    x1  = longint'($signed(run_drift)) + v;
    x2  = longint'($signed(run_drift)) - v;
    run_sum  = run_sum + payoff_at(x1) + payoff_at(x2);
    run_seen = run_seen + 1'b1;
    n = 64'(regs.path_count);
    if (n == 0) n = 1;
    if (n > 64'(aepa_pkg::MaxPaths)) n = 64'(aepa_pkg::MaxPaths);
    if (64'(run_seen) >= n) begin
      mean = run_sum / (2 * n);
      p    = (mean * 64'(run_disc)) >> 24;
      price_q = {price_q, ((p > Sat32) ? 32'hFFFF_FFFF : p[31:0])};
      run_sum  = '0;
      run_seen = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  // register write; valid is left high and dropped by the next request sent
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    n_writes++;
    case (aepa_pkg::cfg_idx_t'(idx))
      aepa_pkg::CfgSpot:   regs.spot       = val;
      aepa_pkg::CfgStrike: regs.strike     = val;
      aepa_pkg::CfgRate:   regs.rate       = val[29:0];
      aepa_pkg::CfgVol:    regs.volatility = val[30:0];
      aepa_pkg::CfgMat:    regs.maturity   = val[29:0];
      aepa_pkg::CfgIsCall: regs.is_call    = val[0];
      aepa_pkg::CfgPaths:  regs.path_count = val[20:0];
      default:   ;
    endcase
  endtask

  task automatic send_draw(logic signed [31:0] z);
    cfg_ch.valid <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.normal_sample <= z;
    do @(posedge clk); while (!sample_ch.ready);
    n_samples++;
    price_draw(z);
  endtask

  // all prices in, then room for a draw still in flight with no result
  task automatic settle();
    sample_ch.valid <= 1'b0;
    cfg_ch.valid    <= 1'b0;
    while (price_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_draw();
    case ($urandom_range(7))
      0:       return $urandom();                               // any bit pattern
      1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    price_ch.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && price_ch.valid && price_ch.ready) begin
      n_prices++;
      if (price_q.size() == 0) report("price with none expected", price_ch.price, '0);
      else begin
        if (price_ch.price !== price_q[0]) report("price", price_ch.price, price_q[0]);
        void'(price_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (price_ch.valid && price_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("Timeout: nothing moved for %0d cycles", StallLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // extreme draws, one per run, call and put, zero path count
  task automatic test_extreme_draws();
    write_reg(aepa_pkg::CfgPaths, 32'd1);
    send_draw(32'sh0000_0000);
    send_draw(32'sh7FFF_FFFF);
    send_draw(32'sh8000_0000);
    send_draw(32'sh1000_0000);
    send_draw(-32'sh1000_0000);
    send_draw(32'sh0000_0001);
    send_draw(-32'sh0000_0001);
    settle();
    write_reg(aepa_pkg::CfgIsCall, 32'd0);
    write_reg(aepa_pkg::CfgPaths, 32'd0);           // zero count acts as one
    send_draw(32'sh7FFF_FFFF);
    send_draw(32'sh8000_0000);
    send_draw(32'sh2000_0000);
    settle();
  endtask

  // register extremes, including zero values and the unused index
  task automatic test_reg_extremes();
    write_reg(aepa_pkg::CfgSpot, 32'hFFFF_FFFF);
    write_reg(aepa_pkg::CfgStrike, 32'd1);
    write_reg(aepa_pkg::CfgIsCall, 32'hFFFF_FFFF);
    write_reg(aepa_pkg::CfgVol, 32'h7FFF_FFFF);
    write_reg(aepa_pkg::CfgMat, 32'h3FFF_FFFF);
    write_reg(aepa_pkg::CfgRate, 32'h2000_0000);    // most negative rate
    write_reg(CfgNone, 32'hFFFF_FFFF);
    write_reg(aepa_pkg::CfgPaths, 32'd2);
    send_draw(32'sh0800_0000);
    send_draw(-32'sh0800_0000);
    settle();
    write_reg(aepa_pkg::CfgRate, 32'h1FFF_FFFF);    // most positive rate
    write_reg(aepa_pkg::CfgSpot, 32'd0);
    write_reg(aepa_pkg::CfgStrike, 32'hFFFF_FFFF);
    write_reg(aepa_pkg::CfgVol, 32'd0);
    write_reg(aepa_pkg::CfgMat, 32'd0);
    write_reg(aepa_pkg::CfgIsCall, 32'd0);
    write_reg(aepa_pkg::CfgPaths, 32'd1);
    send_draw(32'sh1000_0000);
    settle();
  endtask

  // writes inside an open run, and a path count dropped below the draws seen
  task automatic test_mid_run();
    write_reg(aepa_pkg::CfgSpot, 32'd6553600);
    write_reg(aepa_pkg::CfgStrike, 32'd6000000);
    write_reg(aepa_pkg::CfgRate, 32'd13421773);
    write_reg(aepa_pkg::CfgVol, 32'd214748365);
    write_reg(aepa_pkg::CfgMat, 32'd16777216);
    write_reg(aepa_pkg::CfgIsCall, 32'd1);
    write_reg(aepa_pkg::CfgPaths, 32'h001F_FFFF);   // saturates to the path limit
    send_draw(32'sh0400_0000);
    send_draw(-32'sh0C00_0000);
    send_draw(32'sh1800_0000);
    settle();
    // rate, vol and maturity wait for the next run; spot and strike act now
    write_reg(aepa_pkg::CfgRate, 32'h3000_0000);
    write_reg(aepa_pkg::CfgVol, 32'd800000000);
    write_reg(aepa_pkg::CfgSpot, 32'd7000000);
    write_reg(aepa_pkg::CfgStrike, 32'd6500000);
    write_reg(aepa_pkg::CfgPaths, 32'd1);
    send_draw(32'sh0200_0000);            // closes the run
    send_draw(32'sh0200_0000);            // new run with new terms
    settle();
  endtask

  task automatic random_regs();
    if ($urandom_range(5) == 0) begin
      write_reg(aepa_pkg::CfgSpot, $urandom());
      write_reg(aepa_pkg::CfgStrike, $urandom());
      write_reg(aepa_pkg::CfgRate, $urandom());
      write_reg(aepa_pkg::CfgVol, $urandom());
      write_reg(aepa_pkg::CfgMat, $urandom());
    end else begin
      write_reg(aepa_pkg::CfgSpot, $urandom_range(32'h0200_0000, 32'h0010_0000));
      write_reg(aepa_pkg::CfgStrike, $urandom_range(32'h0200_0000, 32'h0010_0000));
      write_reg(aepa_pkg::CfgRate, 32'($signed($urandom_range(200000000)) - 100000000));
      write_reg(aepa_pkg::CfgVol, $urandom_range(900000000, 20000000));
      write_reg(aepa_pkg::CfgMat, $urandom_range(100000000, 1000000));
    end
    write_reg(aepa_pkg::CfgIsCall, $urandom());
    write_reg(aepa_pkg::CfgPaths,
              $urandom_range(6, 1) | ($urandom_range(15) == 0 ? 32'hFFE0_0000 : 0));
    if ($urandom_range(7) == 0) write_reg(CfgNone, $urandom());
  endtask

  // random draws under each idling pattern, new settings every 12 draws
  task automatic test_random(int sender, int receiver, int count);
    idle_pct  = sender;
    stall_pct = receiver;
    for (int i = 0; i < count; i++) begin
      if (i % 12 == 0) begin
        settle();
        random_regs();
      end
      send_draw(rand_draw());
    end
    settle();
  endtask

  initial begin
    sample_ch.valid         = 1'b0;
    sample_ch.normal_sample = '0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = '0;
    cfg_ch.data             = '0;
    regs     = '{aepa_pkg::SpotReset, aepa_pkg::StrikeReset, aepa_pkg::RateReset,
                 aepa_pkg::VolReset, aepa_pkg::MatReset, 1'b1, aepa_pkg::PathsReset};
    run_sum  = '0;
    run_seen = '0;
    run_drift = '0;
    run_vol  = '0;
    run_disc = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_draws();
    test_reg_extremes();
    test_mid_run();
    test_random(0, 0, 160);
    test_random(57, 0, 160);
    test_random(0, 57, 160);
    test_random(35, 35, 160);

    settle();
    $display("Covered %0d draws, %0d prices, %0d register writes", n_samples, n_prices,
             n_writes);
    $display("Call and put, extreme draws and registers, mid-run writes, four idle patterns");
    if (errors == 0 && price_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors, %0d prices never seen", errors, price_q.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
